/* hdl/ehp_pkg.sv */
// Shared types and constants for the Ethernet header parser.
package ehp_pkg;

  localparam int EHP_MAX_FRAME_BYTES_DEF = 2048;
  localparam int EHP_QUEUE_DEPTH         = 2;
  localparam int EHP_OUT_DATA_W          = 280;
  localparam int EHP_KIND_W              = 3;

  localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP  = 8'h11;
  localparam logic [7:0]  IP_PROTO_TCP  = 8'h06;

  localparam logic [EHP_KIND_W-1:0] KIND_OTHER     = 3'd0;
  localparam logic [EHP_KIND_W-1:0] KIND_ARP       = 3'd1;
  localparam logic [EHP_KIND_W-1:0] KIND_UDP       = 3'd2;
  localparam logic [EHP_KIND_W-1:0] KIND_TCP_MQTT  = 3'd3;
  localparam logic [EHP_KIND_W-1:0] KIND_TCP_OTHER = 3'd4;
  localparam logic [EHP_KIND_W-1:0] KIND_IPV4      = 3'd5;

  // Raw per-frame capture handed from front to back.
  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] src_mac;
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [31:0] peer_ip;
    logic [31:0] target_ip;
    logic [7:0]  protocol;
    logic [47:0] udp_fields;
    logic [7:0]  mqtt_byte;
    logic [31:0] tail;
    logic        len_ge4;
    logic        len_ge34;
    logic        len_ge42;
  } frame_rec_t;

endpackage

/* hdl/ehp_front.sv */
// Byte capture front end: tracks position, captures header fields, emits one record per frame.
module ehp_front import ehp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = EHP_MAX_FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rec_push,
  output frame_rec_t rec_data
);

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [47:0] dest_mac_r, dest_mac_nxt;
  logic [47:0] src_mac_r, src_mac_nxt;
  logic [15:0] ether_type_r, ether_type_nxt;
  logic [15:0] arp_opcode_r, arp_opcode_nxt;
  logic [31:0] peer_ip_r, peer_ip_nxt;
  logic [31:0] target_ip_r, target_ip_nxt;
  logic [7:0]  protocol_r, protocol_nxt;
  logic [3:0]  ihl_r, ihl_nxt;
  logic [47:0] udp_r, udp_nxt;
  logic [7:0]  mqtt_r, mqtt_nxt;
  logic [31:0] tail_r, tail_nxt;
  logic [6:0]  udp_start;
  logic [POS_W-1:0] udp_lo;
  logic [POS_W-1:0] udp_hi;

  always_comb begin
    pos_nxt        = pos_r;
    dest_mac_nxt   = dest_mac_r;
    src_mac_nxt    = src_mac_r;
    ether_type_nxt = ether_type_r;
    arp_opcode_nxt = arp_opcode_r;
    peer_ip_nxt    = peer_ip_r;
    target_ip_nxt  = target_ip_r;
    protocol_nxt   = protocol_r;
    ihl_nxt        = ihl_r;
    udp_nxt        = udp_r;
    mqtt_nxt       = mqtt_r;
    tail_nxt       = {data_byte, tail_r[31:8]};

    if ((pos_r == POS_W'(14)) && (ether_type_r == ETH_TYPE_IPV4)) begin
      ihl_nxt = data_byte[3:0];
    end
    // IHL written on byte 14 applies to that same byte
    udp_start = 7'd14 + {1'b0, ihl_nxt, 2'b00};
    udp_lo    = POS_W'(udp_start);
    udp_hi    = POS_W'(udp_start) + POS_W'(6);

    if (pos_r < POS_W'(MAX_FRAME_BYTES)) begin
      pos_nxt = pos_r + POS_W'(1);
      if (pos_r < POS_W'(6)) begin
        dest_mac_nxt = {dest_mac_r[39:0], data_byte};
      end else if (pos_r < POS_W'(12)) begin
        src_mac_nxt = {src_mac_r[39:0], data_byte};
      end else if (pos_r < POS_W'(14)) begin
        ether_type_nxt = {ether_type_r[7:0], data_byte};
      end else if (ether_type_r == ETH_TYPE_ARP) begin
        if ((pos_r == POS_W'(20)) || (pos_r == POS_W'(21))) begin
          arp_opcode_nxt = {arp_opcode_r[7:0], data_byte};
        end else if ((pos_r >= POS_W'(28)) && (pos_r <= POS_W'(31))) begin
          peer_ip_nxt = {peer_ip_r[23:0], data_byte};
        end else if ((pos_r >= POS_W'(38)) && (pos_r <= POS_W'(41))) begin
          target_ip_nxt = {target_ip_r[23:0], data_byte};
        end
      end else if (ether_type_r == ETH_TYPE_IPV4) begin
        if (pos_r == POS_W'(23)) begin
          protocol_nxt = data_byte;
        end
        if ((pos_r >= POS_W'(26)) && (pos_r <= POS_W'(29))) begin
          peer_ip_nxt = {peer_ip_r[23:0], data_byte};
        end
        if ((pos_r >= POS_W'(30)) && (pos_r <= POS_W'(33))) begin
          target_ip_nxt = {target_ip_r[23:0], data_byte};
        end
        if ((pos_r >= udp_lo) && (pos_r < udp_hi)) begin
          udp_nxt = {udp_r[39:0], data_byte};
        end
      end
      if (pos_r == POS_W'(54)) begin
        mqtt_nxt = data_byte;
      end
    end
  end

  assign rec_push            = byte_accept && last_byte;
  assign rec_data.dest_mac   = dest_mac_nxt;
  assign rec_data.src_mac    = src_mac_nxt;
  assign rec_data.ether_type = ether_type_nxt;
  assign rec_data.arp_opcode = arp_opcode_nxt;
  assign rec_data.peer_ip    = peer_ip_nxt;
  assign rec_data.target_ip  = target_ip_nxt;
  assign rec_data.protocol   = protocol_nxt;
  assign rec_data.udp_fields = udp_nxt;
  assign rec_data.mqtt_byte  = mqtt_nxt;
  assign rec_data.tail       = tail_nxt;
  assign rec_data.len_ge4    = pos_nxt >= POS_W'(4);
  assign rec_data.len_ge34   = pos_nxt >= POS_W'(34);
  assign rec_data.len_ge42   = pos_nxt >= POS_W'(42);

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_accept && last_byte)) begin
      pos_r        <= '0;
      dest_mac_r   <= '0;
      src_mac_r    <= '0;
      ether_type_r <= '0;
      arp_opcode_r <= '0;
      peer_ip_r    <= '0;
      target_ip_r  <= '0;
      protocol_r   <= '0;
      ihl_r        <= '0;
      udp_r        <= '0;
      mqtt_r       <= '0;
      tail_r       <= '0;
    end else if (byte_accept) begin
      pos_r        <= pos_nxt;
      dest_mac_r   <= dest_mac_nxt;
      src_mac_r    <= src_mac_nxt;
      ether_type_r <= ether_type_nxt;
      arp_opcode_r <= arp_opcode_nxt;
      peer_ip_r    <= peer_ip_nxt;
      target_ip_r  <= target_ip_nxt;
      protocol_r   <= protocol_nxt;
      ihl_r        <= ihl_nxt;
      udp_r        <= udp_nxt;
      mqtt_r       <= mqtt_nxt;
      tail_r       <= tail_nxt;
    end
  end

endmodule

/* hdl/ehp_queue.sv */
// Short record queue between the capture front end and the summary back end.
module ehp_queue import ehp_pkg::*; #(
  parameter int DEPTH = EHP_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_data,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output frame_rec_t head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = cnt_r == CNT_W'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

/* hdl/ehp_back.sv */
// Summary back end: classifies a frame record, masks fields, holds the output word.
module ehp_back import ehp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rec_valid,
  input  frame_rec_t                rec,
  output logic                      rec_pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [EHP_OUT_DATA_W-1:0] out_tdata,
  output logic [EHP_KIND_W-1:0]     out_tuser
);

  logic                      valid_r;
  logic [EHP_OUT_DATA_W-1:0] data_r, data_nxt;
  logic [EHP_KIND_W-1:0]     kind_r, kind_nxt;
  logic                      is_arp, is_ipv4, is_udp, is_mqtt;

  always_comb begin
    is_arp  = (rec.ether_type == ETH_TYPE_ARP) && rec.len_ge42;
    is_ipv4 = (rec.ether_type == ETH_TYPE_IPV4) && rec.len_ge34;
    is_udp  = is_ipv4 && (rec.protocol == IP_PROTO_UDP) && rec.len_ge42;

    unique case (rec.mqtt_byte[7:4])
      4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd12, 4'd13, 4'd14: is_mqtt = 1'b1;
      default:                                          is_mqtt = 1'b0;
    endcase

    priority if (is_arp) begin
      kind_nxt = KIND_ARP;
    end else if (!is_ipv4) begin
      kind_nxt = KIND_OTHER;
    end else if (is_udp) begin
      kind_nxt = KIND_UDP;
    end else if (rec.protocol == IP_PROTO_TCP) begin
      kind_nxt = is_mqtt ? KIND_TCP_MQTT : KIND_TCP_OTHER;
    end else begin
      kind_nxt = KIND_IPV4;
    end

    data_nxt = {
      rec.len_ge4 ? rec.tail : 32'd0,
      is_udp ? rec.udp_fields : 48'd0,
      is_ipv4 ? rec.protocol : 8'd0,
      (is_arp || is_ipv4) ? rec.target_ip : 32'd0,
      (is_arp || is_ipv4) ? rec.peer_ip : 32'd0,
      is_arp ? rec.arp_opcode : 16'd0,
      rec.ether_type,
      rec.src_mac,
      rec.dest_mac
    };
  end

  assign rec_pop    = rec_valid && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (rec_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_pop) begin
      data_r <= data_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule

/* hdl/ethernet_header_parser.sv */
// Ethernet header parser: bytes in, one summary word per frame out.
// Throughput: one byte word per cycle while in_tready is high, no gaps between frames.
// A frame's summary goes into the queue with its last byte, then into the output register.
// A two-record queue and the output register let input flow under stall until the queue fills.
// Reset (rst_n low, synchronous) clears the byte position, all captures and the queue.
module ethernet_header_parser import ehp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = EHP_MAX_FRAME_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // [7:0] data_byte
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [47:0] dest_mac, [95:48] src_mac, [111:96] ether_type, [127:112] arp_opcode,
  // [159:128] peer_ip, [191:160] target_ip, [199:192] ip_protocol,
  // [215:200] udp_length, [231:216] dst_port, [247:232] src_port, [279:248] frame_check
  output logic [EHP_OUT_DATA_W-1:0] out_tdata,
  output logic [EHP_KIND_W-1:0]     out_tuser   // [2:0] frame_kind
);

  logic       q_full, q_not_empty, push, pop;
  frame_rec_t push_rec, head_rec;

  assign in_tready = !q_full;

  ehp_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_accept(in_tvalid && in_tready),
    .data_byte  (in_tdata),
    .last_byte  (in_tlast),
    .rec_push   (push),
    .rec_data   (push_rec)
  );

  ehp_queue #(
    .DEPTH(EHP_QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_rec),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_not_empty),
    .head_data(head_rec)
  );

  ehp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_not_empty),
    .rec       (head_rec),
    .rec_pop   (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
